// ===== sv/tbc_pkg.sv =====
// Types, tables and round functions for the SKINNY-128-384 pipeline.
`default_nettype none
package tbc_pkg;

	// Cell 0 sits in the most significant byte.
	typedef logic [0:15][7:0] cells_t;

	typedef struct packed {
		cells_t k1;
		cells_t k2;
		cells_t k3;
	} tk_t;

	typedef struct packed {
		logic   dec;
		cells_t st;
		tk_t    tk;
	} item_t;

	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	localparam logic [7:0] SBOX_FWD [256] = '{
		8'h65, 8'h4c, 8'h6a, 8'h42, 8'h4b, 8'h63, 8'h43, 8'h6b,
		8'h55, 8'h75, 8'h5a, 8'h7a, 8'h53, 8'h73, 8'h5b, 8'h7b,
		8'h35, 8'h8c, 8'h3a, 8'h81, 8'h89, 8'h33, 8'h80, 8'h3b,
		8'h95, 8'h25, 8'h98, 8'h2a, 8'h90, 8'h23, 8'h99, 8'h2b,
		8'he5, 8'hcc, 8'he8, 8'hc1, 8'hc9, 8'he0, 8'hc0, 8'he9,
		8'hd5, 8'hf5, 8'hd8, 8'hf8, 8'hd0, 8'hf0, 8'hd9, 8'hf9,
		8'ha5, 8'h1c, 8'ha8, 8'h12, 8'h1b, 8'ha0, 8'h13, 8'ha9,
		8'h05, 8'hb5, 8'h0a, 8'hb8, 8'h03, 8'hb0, 8'h0b, 8'hb9,
		8'h32, 8'h88, 8'h3c, 8'h85, 8'h8d, 8'h34, 8'h84, 8'h3d,
		8'h91, 8'h22, 8'h9c, 8'h2c, 8'h94, 8'h24, 8'h9d, 8'h2d,
		8'h62, 8'h4a, 8'h6c, 8'h45, 8'h4d, 8'h64, 8'h44, 8'h6d,
		8'h52, 8'h72, 8'h5c, 8'h7c, 8'h54, 8'h74, 8'h5d, 8'h7d,
		8'ha1, 8'h1a, 8'hac, 8'h15, 8'h1d, 8'ha4, 8'h14, 8'had,
		8'h02, 8'hb1, 8'h0c, 8'hbc, 8'h04, 8'hb4, 8'h0d, 8'hbd,
		8'he1, 8'hc8, 8'hec, 8'hc5, 8'hcd, 8'he4, 8'hc4, 8'hed,
		8'hd1, 8'hf1, 8'hdc, 8'hfc, 8'hd4, 8'hf4, 8'hdd, 8'hfd,
		8'h36, 8'h8e, 8'h38, 8'h82, 8'h8b, 8'h30, 8'h83, 8'h39,
		8'h96, 8'h26, 8'h9a, 8'h28, 8'h93, 8'h20, 8'h9b, 8'h29,
		8'h66, 8'h4e, 8'h68, 8'h41, 8'h49, 8'h60, 8'h40, 8'h69,
		8'h56, 8'h76, 8'h58, 8'h78, 8'h50, 8'h70, 8'h59, 8'h79,
		8'ha6, 8'h1e, 8'haa, 8'h11, 8'h19, 8'ha3, 8'h10, 8'hab,
		8'h06, 8'hb6, 8'h08, 8'hba, 8'h00, 8'hb3, 8'h09, 8'hbb,
		8'he6, 8'hce, 8'hea, 8'hc2, 8'hcb, 8'he3, 8'hc3, 8'heb,
		8'hd6, 8'hf6, 8'hda, 8'hfa, 8'hd3, 8'hf3, 8'hdb, 8'hfb,
		8'h31, 8'h8a, 8'h3e, 8'h86, 8'h8f, 8'h37, 8'h87, 8'h3f,
		8'h92, 8'h21, 8'h9e, 8'h2e, 8'h97, 8'h27, 8'h9f, 8'h2f,
		8'h61, 8'h48, 8'h6e, 8'h46, 8'h4f, 8'h67, 8'h47, 8'h6f,
		8'h51, 8'h71, 8'h5e, 8'h7e, 8'h57, 8'h77, 8'h5f, 8'h7f,
		8'ha2, 8'h18, 8'hae, 8'h16, 8'h1f, 8'ha7, 8'h17, 8'haf,
		8'h01, 8'hb2, 8'h0e, 8'hbe, 8'h07, 8'hb7, 8'h0f, 8'hbf,
		8'he2, 8'hca, 8'hee, 8'hc6, 8'hcf, 8'he7, 8'hc7, 8'hef,
		8'hd2, 8'hf2, 8'hde, 8'hfe, 8'hd7, 8'hf7, 8'hdf, 8'hff
	};

	localparam logic [7:0] SBOX_REV [256] = '{
		8'hac, 8'he8, 8'h68, 8'h3c, 8'h6c, 8'h38, 8'ha8, 8'hec,
		8'haa, 8'hae, 8'h3a, 8'h3e, 8'h6a, 8'h6e, 8'hea, 8'hee,
		8'ha6, 8'ha3, 8'h33, 8'h36, 8'h66, 8'h63, 8'he3, 8'he6,
		8'he1, 8'ha4, 8'h61, 8'h34, 8'h31, 8'h64, 8'ha1, 8'he4,
		8'h8d, 8'hc9, 8'h49, 8'h1d, 8'h4d, 8'h19, 8'h89, 8'hcd,
		8'h8b, 8'h8f, 8'h1b, 8'h1f, 8'h4b, 8'h4f, 8'hcb, 8'hcf,
		8'h85, 8'hc0, 8'h40, 8'h15, 8'h45, 8'h10, 8'h80, 8'hc5,
		8'h82, 8'h87, 8'h12, 8'h17, 8'h42, 8'h47, 8'hc2, 8'hc7,
		8'h96, 8'h93, 8'h03, 8'h06, 8'h56, 8'h53, 8'hd3, 8'hd6,
		8'hd1, 8'h94, 8'h51, 8'h04, 8'h01, 8'h54, 8'h91, 8'hd4,
		8'h9c, 8'hd8, 8'h58, 8'h0c, 8'h5c, 8'h08, 8'h98, 8'hdc,
		8'h9a, 8'h9e, 8'h0a, 8'h0e, 8'h5a, 8'h5e, 8'hda, 8'hde,
		8'h95, 8'hd0, 8'h50, 8'h05, 8'h55, 8'h00, 8'h90, 8'hd5,
		8'h92, 8'h97, 8'h02, 8'h07, 8'h52, 8'h57, 8'hd2, 8'hd7,
		8'h9d, 8'hd9, 8'h59, 8'h0d, 8'h5d, 8'h09, 8'h99, 8'hdd,
		8'h9b, 8'h9f, 8'h0b, 8'h0f, 8'h5b, 8'h5f, 8'hdb, 8'hdf,
		8'h16, 8'h13, 8'h83, 8'h86, 8'h46, 8'h43, 8'hc3, 8'hc6,
		8'h41, 8'h14, 8'hc1, 8'h84, 8'h11, 8'h44, 8'h81, 8'hc4,
		8'h1c, 8'h48, 8'hc8, 8'h8c, 8'h4c, 8'h18, 8'h88, 8'hcc,
		8'h1a, 8'h1e, 8'h8a, 8'h8e, 8'h4a, 8'h4e, 8'hca, 8'hce,
		8'h35, 8'h60, 8'he0, 8'ha5, 8'h65, 8'h30, 8'ha0, 8'he5,
		8'h32, 8'h37, 8'ha2, 8'ha7, 8'h62, 8'h67, 8'he2, 8'he7,
		8'h3d, 8'h69, 8'he9, 8'had, 8'h6d, 8'h39, 8'ha9, 8'hed,
		8'h3b, 8'h3f, 8'hab, 8'haf, 8'h6b, 8'h6f, 8'heb, 8'hef,
		8'h26, 8'h23, 8'hb3, 8'hb6, 8'h76, 8'h73, 8'hf3, 8'hf6,
		8'h71, 8'h24, 8'hf1, 8'hb4, 8'h21, 8'h74, 8'hb1, 8'hf4,
		8'h2c, 8'h78, 8'hf8, 8'hbc, 8'h7c, 8'h28, 8'hb8, 8'hfc,
		8'h2a, 8'h2e, 8'hba, 8'hbe, 8'h7a, 8'h7e, 8'hfa, 8'hfe,
		8'h25, 8'h70, 8'hf0, 8'hb5, 8'h75, 8'h20, 8'hb0, 8'hf5,
		8'h22, 8'h27, 8'hb2, 8'hb7, 8'h72, 8'h77, 8'hf2, 8'hf7,
		8'h2d, 8'h79, 8'hf9, 8'hbd, 8'h7d, 8'h29, 8'hb9, 8'hfd,
		8'h2b, 8'h2f, 8'hbb, 8'hbf, 8'h7b, 8'h7f, 8'hfb, 8'hff
	};

	localparam int CELL_PERM [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

	// Round constant of round n (0-based), evaluated at elaboration.
	function automatic logic [5:0] rc_at(input int n);
		logic [5:0] l;
		l = 6'd0;
		for (int r = 0; r <= n; r++)
			l = {l[4:0], l[5] ^ l[4] ^ 1'b1};
		return l;
	endfunction

	function automatic logic [7:0] lfsr2(input logic [7:0] a);
		return {a[6:0], a[7] ^ a[5]};
	endfunction

	function automatic logic [7:0] lfsr3(input logic [7:0] c);
		return {c[0] ^ c[6], c[7:1]};
	endfunction

	function automatic tk_t tk_fwd(input tk_t k);
		tk_t o;
		for (int i = 0; i < 16; i++) begin
			o.k1[i] = k.k1[CELL_PERM[i]];
			o.k2[i] = k.k2[CELL_PERM[i]];
			o.k3[i] = k.k3[CELL_PERM[i]];
		end
		for (int i = 0; i < 8; i++) begin
			o.k2[i] = lfsr2(o.k2[i]);
			o.k3[i] = lfsr3(o.k3[i]);
		end
		return o;
	endfunction

	// lfsr3 undoes lfsr2 and the other way around.
	function automatic tk_t tk_inv(input tk_t k);
		tk_t u;
		tk_t o;
		u = k;
		for (int i = 0; i < 8; i++) begin
			u.k2[i] = lfsr3(k.k2[i]);
			u.k3[i] = lfsr2(k.k3[i]);
		end
		for (int i = 0; i < 16; i++) begin
			o.k1[CELL_PERM[i]] = u.k1[i];
			o.k2[CELL_PERM[i]] = u.k2[i];
			o.k3[CELL_PERM[i]] = u.k3[i];
		end
		return o;
	endfunction

	function automatic cells_t add_key(input cells_t s, input tk_t k, input logic [5:0] rc);
		cells_t o;
		o = s;
		o[0] = o[0] ^ {4'd0, rc[3:0]};
		o[4] = o[4] ^ {6'd0, rc[5:4]};
		o[8] = o[8] ^ 8'h02;
		for (int i = 0; i < 8; i++)
			o[i] = o[i] ^ k.k1[i] ^ k.k2[i] ^ k.k3[i];
		return o;
	endfunction

	function automatic cells_t round_enc(input cells_t s, input tk_t k, input logic [5:0] rc);
		cells_t a;
		cells_t t;
		cells_t o;
		for (int i = 0; i < 16; i++)
			a[i] = SBOX_FWD[s[i]];
		a = add_key(a, k, rc);
		// rotate row r right by r cells
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[r*4 + ((c + r) % 4)] = a[r*4 + c];
		for (int c = 0; c < 4; c++) begin
			o[c]      = t[c] ^ t[8+c] ^ t[12+c];
			o[4 + c]  = t[c];
			o[8 + c]  = t[4+c] ^ t[8+c];
			o[12 + c] = t[c] ^ t[8+c];
		end
		return o;
	endfunction

	function automatic cells_t round_dec(input cells_t s, input tk_t k, input logic [5:0] rc);
		cells_t t;
		cells_t a;
		cells_t o;
		for (int c = 0; c < 4; c++) begin
			t[c]      = s[4+c];
			t[4 + c]  = s[4+c] ^ s[8+c] ^ s[12+c];
			t[8 + c]  = s[4+c] ^ s[12+c];
			t[12 + c] = s[c] ^ s[12+c];
		end
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				a[r*4 + c] = t[r*4 + ((c + r) % 4)];
		a = add_key(a, k, rc);
		for (int i = 0; i < 16; i++)
			o[i] = SBOX_REV[a[i]];
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== sv/tweakable_block_cipher_128_384_core.sv =====
// SKINNY-128-384 encrypt/decrypt core, one round per round stage of the pipeline.
// Throughput: one block per cycle; busy stays low, the stage chain never stalls.
// The first ROUNDS stages roll the tweakey forward for decryption, the next
// ROUNDS stages each run one round of the cipher.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none
module tweakable_block_cipher_128_384_core #(
	parameter int ROUNDS = 56
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [63:0] block_hi,
	input  wire logic [63:0] block_lo,
	input  wire logic [63:0] tk1_hi,
	input  wire logic [63:0] tk1_lo,
	input  wire logic [63:0] tk2_hi,
	input  wire logic [63:0] tk2_lo,
	input  wire logic [63:0] tk3_hi,
	input  wire logic [63:0] tk3_lo,
	output logic             done,
	output logic [63:0]      result_hi,
	output logic [63:0]      result_lo
);

	localparam int DEPTH = 2 * ROUNDS;

	tbc_pkg::item_t     pipe_s [DEPTH+1];
	logic [DEPTH:0]     vld_s;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DEPTH-1:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0].dec   <= (opcode == tbc_pkg::OP_DEC);
		pipe_s[0].st    <= {block_hi, block_lo};
		pipe_s[0].tk.k1 <= {tk1_hi, tk1_lo};
		pipe_s[0].tk.k2 <= {tk2_hi, tk2_lo};
		pipe_s[0].tk.k3 <= {tk3_hi, tk3_lo};
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_stage
		if (g < ROUNDS) begin : g_roll
			// advance the tweakey for decryption, hold it for encryption
			always_ff @(posedge clk) begin
				pipe_s[g+1].dec <= pipe_s[g].dec;
				pipe_s[g+1].st  <= pipe_s[g].st;
				pipe_s[g+1].tk  <= pipe_s[g].dec ? tbc_pkg::tk_fwd(pipe_s[g].tk)
					: pipe_s[g].tk;
			end
		end else begin : g_round
			localparam logic [5:0] RC_ENC = tbc_pkg::rc_at(g - ROUNDS);
			localparam logic [5:0] RC_DEC = tbc_pkg::rc_at(DEPTH - 1 - g);
			tbc_pkg::tk_t tk_back;
			assign tk_back = tbc_pkg::tk_inv(pipe_s[g].tk);
			always_ff @(posedge clk) begin
				pipe_s[g+1].dec <= pipe_s[g].dec;
				if (pipe_s[g].dec) begin
					pipe_s[g+1].st <= tbc_pkg::round_dec(pipe_s[g].st, tk_back, RC_DEC);
					pipe_s[g+1].tk <= tk_back;
				end else begin
					pipe_s[g+1].st <= tbc_pkg::round_enc(pipe_s[g].st, pipe_s[g].tk,
						RC_ENC);
					pipe_s[g+1].tk <= tbc_pkg::tk_fwd(pipe_s[g].tk);
				end
			end
		end
	end

	assign done      = vld_s[DEPTH];
	assign result_hi = pipe_s[DEPTH].st[0:7];
	assign result_lo = pipe_s[DEPTH].st[8:15];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(DEPTH+1) done)
		else $error("transaction lost in pipeline");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s[0], DEPTH))
		else $error("result without a transaction");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("busy raised");

endmodule
`default_nettype wire

// ===== tb/tweakable_block_cipher_128_384_core_checker.sv =====
// Result checker for the SKINNY-128-384 core: predicts each block and compares.
`timescale 1ns / 100ps
module tweakable_block_cipher_128_384_core_checker #(
	parameter int ROUNDS = 56
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        opcode,
	input  wire logic [63:0] block_hi,
	input  wire logic [63:0] block_lo,
	input  wire logic [63:0] tk1_hi,
	input  wire logic [63:0] tk1_lo,
	input  wire logic [63:0] tk2_hi,
	input  wire logic [63:0] tk2_lo,
	input  wire logic [63:0] tk3_hi,
	input  wire logic [63:0] tk3_lo,
	input  wire logic        done,
	input  wire logic [63:0] result_hi,
	input  wire logic [63:0] result_lo,
	output int               errors,
	output int               pending
);

	logic [127:0] cipher_q[$];

	localparam logic [7:0] FWD [256] = '{
		8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
		8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
		8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
		8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
		8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
		8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
		8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
		8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
		8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
		8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
		8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
		8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
		8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
		8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
		8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
		8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
	};

	logic [7:0] inv_box [256];
	initial for (int i = 0; i < 256; i++) inv_box[FWD[i]] = 8'(i);

	function automatic logic [127:0] skinny(input logic dec, input logic [127:0] blk,
			input logic [127:0] k1, input logic [127:0] k2, input logic [127:0] k3);
		logic [7:0] s[16], t[16], a[16], b[16], c[16], tmp[16];
		logic [7:0] rkey[64][8];
		logic [5:0] rcon[64];
		logic [5:0] lf;
		logic [7:0] x0, x1, x2, x3;
		logic [127:0] o;
		int r;
		for (int i = 0; i < 16; i++) begin
			s[i] = blk[127-8*i -: 8];
			a[i] = k1[127-8*i -: 8];
			b[i] = k2[127-8*i -: 8];
			c[i] = k3[127-8*i -: 8];
		end
		lf = 6'd0;
		for (r = 0; r < ROUNDS; r++) begin
			for (int i = 0; i < 8; i++) rkey[r][i] = a[i] ^ b[i] ^ c[i];
			for (int i = 0; i < 16; i++) tmp[i] = a[tbc_pkg::CELL_PERM[i]];
			a = tmp;
			for (int i = 0; i < 16; i++) tmp[i] = b[tbc_pkg::CELL_PERM[i]];
			b = tmp;
			for (int i = 0; i < 16; i++) tmp[i] = c[tbc_pkg::CELL_PERM[i]];
			c = tmp;
			for (int i = 0; i < 8; i++) begin
				b[i] = {b[i][6:0], b[i][7] ^ b[i][5]};
				c[i] = {c[i][0] ^ c[i][6], c[i][7:1]};
			end
			lf = {lf[4:0], lf[5] ^ lf[4] ^ 1'b1};
			rcon[r] = lf;
		end
		if (dec == tbc_pkg::OP_ENC) begin
			for (r = 0; r < ROUNDS; r++) begin
				for (int i = 0; i < 16; i++) s[i] = FWD[s[i]];
				s[0] ^= {4'd0, rcon[r][3:0]};
				s[4] ^= {6'd0, rcon[r][5:4]};
				s[8] ^= 8'h02;
				for (int i = 0; i < 8; i++) s[i] ^= rkey[r][i];
				for (int i = 0; i < 16; i++) t[(i & ~3) | (((i & 3) + (i >> 2)) & 3)] = s[i];
				for (int k = 0; k < 4; k++) begin
					x0 = t[k]; x1 = t[4+k]; x2 = t[8+k]; x3 = t[12+k];
					s[k] = x0 ^ x2 ^ x3;
					s[4+k] = x0;
					s[8+k] = x1 ^ x2;
					s[12+k] = x0 ^ x2;
				end
			end
		end else begin
			for (r = ROUNDS - 1; r >= 0; r--) begin
				for (int k = 0; k < 4; k++) begin
					x0 = s[k]; x1 = s[4+k]; x2 = s[8+k]; x3 = s[12+k];
					t[k] = x1;
					t[4+k] = x1 ^ x2 ^ x3;
					t[8+k] = x1 ^ x3;
					t[12+k] = x0 ^ x3;
				end
				for (int i = 0; i < 16; i++) s[i] = t[(i & ~3) | (((i & 3) + (i >> 2)) & 3)];
				for (int i = 0; i < 8; i++) s[i] ^= rkey[r][i];
				s[0] ^= {4'd0, rcon[r][3:0]};
				s[4] ^= {6'd0, rcon[r][5:4]};
				s[8] ^= 8'h02;
				for (int i = 0; i < 16; i++) s[i] = inv_box[s[i]];
			end
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
		return o;
	endfunction

	initial errors = 0;
	assign pending = cipher_q.size();

	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n) begin
			if (start && !busy)
				cipher_q.push_back(skinny(opcode, {block_hi, block_lo}, {tk1_hi, tk1_lo},
					{tk2_hi, tk2_lo}, {tk3_hi, tk3_lo}));
			if (done) begin
				if (cipher_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h %h", result_hi, result_lo);
				end else begin
					want = cipher_q.pop_front();
					if (result_hi !== want[127:64] || result_lo !== want[63:0]) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h %h got %h %h",
								want[127:64], want[63:0], result_hi, result_lo);
					end
				end
			end
		end
	end
endmodule

// ===== tb/tweakable_block_cipher_128_384_core_test.sv =====
// Stimulus and verdict for the SKINNY-128-384 core.
`timescale 1ns / 100ps
module tweakable_block_cipher_128_384_core_test;

	localparam int LATENCY = 2 * 56 + 1;
	localparam int WATCHDOG = 4 * LATENCY + 200;

	logic clk = 0, arst_n = 0, start = 0, opcode = 0;
	logic [63:0] block_hi = 0, block_lo = 0, tk1_hi = 0, tk1_lo = 0;
	logic [63:0] tk2_hi = 0, tk2_lo = 0, tk3_hi = 0, tk3_lo = 0;
	logic busy, done;
	logic [63:0] result_hi, result_lo;
	int errors, pending, idle_cycles;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	tweakable_block_cipher_128_384_core dut (.*);
	tweakable_block_cipher_128_384_core_checker chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tweakable_block_cipher_128_384_core verification failed");
			$finish;
		end
	end
	initial idle_cycles = 0;

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick64(input int mode);
		case (mode)
			0: return '0;
			1: return '1;
			default: return rnd64();
		endcase
	endfunction

	// Present one transaction and hold until it is accepted.
	task automatic send(input logic op, input logic [63:0] b0, b1, a0, a1, c0, c1, d0, d1);
		start <= 1;
		opcode <= op;
		block_hi <= b0; block_lo <= b1;
		tk1_hi <= a0; tk1_lo <= a1;
		tk2_hi <= c0; tk2_lo <= c1;
		tk3_hi <= d0; tk3_lo <= d1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_random(input int mode);
		send(tbc_pkg::op_t'($urandom_range(0, 1)), pick64(mode), pick64(mode), pick64(mode),
			pick64(mode), pick64(mode), pick64(mode), pick64(mode), pick64(mode));
	endtask

	initial begin
		int burst;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// extremes of every field with both operations
		for (int m = 0; m < 2; m++) begin
			send(tbc_pkg::OP_ENC, pick64(m), pick64(m), pick64(m), pick64(m), pick64(m),
				pick64(m), pick64(m), pick64(m));
			send(tbc_pkg::OP_DEC, pick64(m), pick64(m), pick64(m), pick64(m), pick64(m),
				pick64(m), pick64(m), pick64(m));
		end
		for (int i = 0; i < 8; i++) begin
			send(tbc_pkg::OP_ENC, '1, '0, '0, '1, '1, '0, '0, '1);
			send(tbc_pkg::OP_DEC, 64'h1 << (i * 8), rnd64(), '0, '0, rnd64(), '0, '0,
				rnd64());
		end
		start <= 0;
		// wait until the pipeline has drained
		while (pending != 0) @(negedge clk);
		for (int n = 0; n < 1330; n++) begin
			if (n % 200 == 0) begin
				burst = $urandom_range(1, 40);
			end
			send_random($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
			burst--;
			if (burst <= 0) begin
				start <= 0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
				burst = $urandom_range(1, 60);
			end
		end
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0)
			$display("tweakable_block_cipher_128_384_core verification clean");
		else
			$display("tweakable_block_cipher_128_384_core verification failed");
		$finish;
	end
endmodule
